// ===== sv/lba_pkg.sv =====
// Package: constants, types and codes of the linked block allocator.
package lba_pkg;

    localparam int NUM_BLOCKS = 256;
    localparam int NUM_IDS    = 1024;
    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int ID_W       = $clog2(NUM_IDS);
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

    localparam logic [8:0] MAX_RESET = 9'd20;
    localparam logic [8:0] MIN_RESET = 9'd2;

    typedef enum logic [1:0] {
        K_CREATE = 2'd0,
        K_DELETE = 2'd1,
        K_READ   = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_CANCEL  = 3'd1,
        ST_SIZE    = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_NOID    = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        CFG_MAX = 1'b0,
        CFG_MIN = 1'b1
    } t_cfg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_IDSCAN,
        S_IDWAIT,
        S_BSCAN,
        S_BWAIT,
        S_BLINK,
        S_DHEAD,
        S_DWAIT,
        S_DSTEP,
        S_RWAIT,
        S_DONE
    } t_state;

    // Block table entry: free flag, owner, end flag, link.
    typedef struct packed {
        logic             free;
        logic [ID_W-1:0]  owner;
        logic             last;
        logic [BLK_W-1:0] next;
    } t_entry;

endpackage

// ===== sv/linked_block_allocator_top.sv =====
// Top level: linked block allocator with block table, id bitmap and head table.
//
// Each request gives one result. After reset a clearing pass runs before the
// first request is taken; it writes one id bitmap entry a cycle, and one block
// entry a cycle until all block entries are cleared. Cancel, size reject and
// the unused kind are written to the output register in the accepting cycle.
// A read is one block table access; a delete reads the id bitmap and head
// table, then frees each block of its chain in turn; a create scans ids, then
// scans blocks for free ones and claims and links each in turn: every step goes
// through the registered-read memories, one access at a time. A new request is
// taken only in the idle state, when the output register is empty or its result leaves in the same cycle.
module linked_block_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [8:0] block_count, [18:9] file_id, [26:19] block_index, [31:27] zero
    input  logic [31:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [12:3] assigned_id, [20:13] head_block, [30:21] entry_owner,
    // [31] entry_free, [39:32] entry_next, [40] entry_last, [49:41] free_blocks,
    // [55:50] zero
    output logic [55:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    import lba_pkg::*;

    localparam int CLR_W = ID_W > BLK_W ? ID_W : BLK_W;

    // block table memory
    t_entry           bt_mem [NUM_BLOCKS];
    logic             bt_we;
    logic [BLK_W-1:0] bt_waddr, bt_raddr;
    t_entry           bt_wdata, bt_rdata;
    // id bitmap memory
    logic             id_mem [NUM_IDS];
    logic             id_we;
    logic [ID_W-1:0]  id_waddr, id_raddr;
    logic             id_wdata, id_rdata;
    // head table memory, undefined until written
    logic [BLK_W-1:0] hd_mem [NUM_IDS];
    logic             hd_we;
    logic [ID_W-1:0]  hd_waddr, hd_raddr;
    logic [BLK_W-1:0] hd_wdata, hd_rdata;

    always_ff @(posedge i_clk) begin
        if (bt_we) bt_mem[bt_waddr] <= bt_wdata;
        bt_rdata <= bt_mem[bt_raddr];
        if (id_we) id_mem[id_waddr] <= id_wdata;
        id_rdata <= id_mem[id_raddr];
        if (hd_we) hd_mem[hd_waddr] <= hd_wdata;
        hd_rdata <= hd_mem[hd_raddr];
    end

    t_state           r_state, n_state;
    logic [CLR_W:0]   r_clr, n_clr;
    logic [8:0]       r_max, r_min;
    logic [CNT_W-1:0] r_free, n_free;
    logic [8:0]       r_cnt, n_cnt;
    logic [ID_W-1:0]  r_fid, n_fid;
    logic [ID_W:0]    r_scan, n_scan;
    logic [BLK_W:0]   r_bscan, n_bscan;
    logic [8:0]       r_left, n_left;
    logic [BLK_W-1:0] r_prev, n_prev;
    logic [BLK_W-1:0] r_head, n_head;
    logic             r_first, n_first;
    logic [BLK_W:0]   r_steps, n_steps;
    logic             r_ovalid, n_ovalid;
    logic [55:0]      r_odata, n_odata;

    logic s_fire, out_free;
    logic [49:0] res;
    t_status     res_st;
    logic [ID_W-1:0]  res_id;
    logic [BLK_W-1:0] res_head;
    logic [ID_W-1:0]  res_owner;
    logic             res_efree, res_elast;
    logic [BLK_W-1:0] res_next;
    logic             res_go;

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= MAX_RESET;
            r_min <= MIN_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg'(i_cfg_index))
                CFG_MAX: r_max <= i_cfg_data;
                CFG_MIN: r_min <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_free   <= CNT_W'(NUM_BLOCKS);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_free   <= n_free;
            r_ovalid <= n_ovalid;
        end
        r_cnt   <= n_cnt;
        r_fid   <= n_fid;
        r_scan  <= n_scan;
        r_bscan <= n_bscan;
        r_left  <= n_left;
        r_prev  <= n_prev;
        r_head  <= n_head;
        r_first <= n_first;
        r_steps <= n_steps;
        r_odata <= n_odata;
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_free   = r_free;
        n_cnt    = r_cnt;
        n_fid    = r_fid;
        n_scan   = r_scan;
        n_bscan  = r_bscan;
        n_left   = r_left;
        n_prev   = r_prev;
        n_head   = r_head;
        n_first  = r_first;
        n_steps  = r_steps;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata  = r_odata;
        bt_we = 1'b0; bt_waddr = '0; bt_wdata = '0; bt_raddr = '0;
        id_we = 1'b0; id_waddr = '0; id_wdata = 1'b0; id_raddr = '0;
        hd_we = 1'b0; hd_waddr = '0; hd_wdata = '0; hd_raddr = '0;
        res_go = 1'b0; res_st = ST_OK; res_id = '0; res_head = '0;
        res_owner = '0; res_efree = 1'b0; res_next = '0; res_elast = 1'b0;

        case (r_state)
            S_CLEAR: begin
                id_we = 1'b1; id_waddr = r_clr[ID_W-1:0];
                if (r_clr < (CLR_W+1)'(NUM_BLOCKS)) begin
                    bt_we = 1'b1; bt_waddr = r_clr[BLK_W-1:0];
                    bt_wdata = '{free: 1'b1, owner: '0, last: 1'b1, next: '0};
                end
                n_clr = r_clr + 1'b1;
                if (r_clr == (CLR_W+1)'(NUM_IDS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_fire) begin
                    n_cnt  = s_axis_tdata[8:0];
                    n_fid  = s_axis_tdata[9+ID_W-1:9];
                    case (t_kind'(s_axis_tuser))
                        K_CREATE: begin
                            if (s_axis_tdata[8:0] == '0) begin
                                res_go = 1'b1; res_st = ST_CANCEL;
                            end else if (s_axis_tdata[8:0] > 9'(r_free)
                                      || s_axis_tdata[8:0] > r_max
                                      || s_axis_tdata[8:0] < r_min) begin
                                res_go = 1'b1; res_st = ST_SIZE;
                            end else begin
                                n_scan = '0; n_state = S_IDSCAN;
                            end
                        end
                        K_DELETE: begin
                            id_raddr = s_axis_tdata[9+ID_W-1:9];
                            hd_raddr = s_axis_tdata[9+ID_W-1:9];
                            n_state  = S_DHEAD;
                        end
                        K_READ: begin
                            bt_raddr = s_axis_tdata[19+BLK_W-1:19];
                            n_state  = S_RWAIT;
                        end
                        default: res_go = 1'b1;
                    endcase
                end
            end
            S_IDSCAN: begin
                if (r_scan == (ID_W+1)'(NUM_IDS)) begin
                    res_go = 1'b1; res_st = ST_NOID; n_state = S_DONE;
                end else begin
                    id_raddr = r_scan[ID_W-1:0];
                    n_state  = S_IDWAIT;
                end
            end
            S_IDWAIT: begin
                if (!id_rdata) begin
                    id_we = 1'b1; id_waddr = r_scan[ID_W-1:0]; id_wdata = 1'b1;
                    n_fid = r_scan[ID_W-1:0];
                    n_left = r_cnt; n_first = 1'b1; n_bscan = '0;
                    n_state = S_BSCAN;
                end else begin
                    n_scan = r_scan + 1'b1; n_state = S_IDSCAN;
                end
            end
            S_BSCAN: begin
                bt_raddr = r_bscan[BLK_W-1:0];
                n_state  = S_BWAIT;
            end
            S_BWAIT: begin
                if (bt_rdata.free) begin
                    bt_we = 1'b1; bt_waddr = r_bscan[BLK_W-1:0];
                    bt_wdata = '{free: 1'b0, owner: r_fid, last: 1'b1, next: '0};
                    if (r_first) begin
                        n_head = r_bscan[BLK_W-1:0];
                        hd_we = 1'b1; hd_waddr = r_fid; hd_wdata = r_bscan[BLK_W-1:0];
                    end
                    n_state = S_BLINK;
                end else begin
                    n_bscan = r_bscan + 1'b1;
                    n_state = S_BSCAN;
                end
            end
            S_BLINK: begin
                if (!r_first) begin
                    bt_we = 1'b1; bt_waddr = r_prev;
                    bt_wdata = '{free: 1'b0, owner: r_fid, last: 1'b0,
                                 next: r_bscan[BLK_W-1:0]};
                end
                n_first = 1'b0;
                n_prev  = r_bscan[BLK_W-1:0];
                n_left  = r_left - 1'b1;
                n_bscan = r_bscan + 1'b1;
                if (r_left == 9'd1) begin
                    n_free = r_free - CNT_W'(r_cnt);
                    res_go = 1'b1; res_id = r_fid; res_head = r_head;
                    n_state = S_DONE;
                end else begin
                    n_state = S_BSCAN;
                end
            end
            S_DHEAD: begin
                if (!id_rdata) begin
                    res_go = 1'b1; res_st = ST_UNKNOWN; n_state = S_DONE;
                end else begin
                    id_we = 1'b1; id_waddr = r_fid; id_wdata = 1'b0;
                    n_prev = hd_rdata; bt_raddr = hd_rdata;
                    n_steps = '0; n_state = S_DSTEP;
                end
            end
            S_DWAIT: begin
                bt_raddr = r_prev;
                n_state  = S_DSTEP;
            end
            S_DSTEP: begin
                bt_we = 1'b1; bt_waddr = r_prev;
                bt_wdata = '{free: 1'b1, owner: '0, last: 1'b1, next: '0};
                if (!bt_rdata.free && r_free < CNT_W'(NUM_BLOCKS))
                    n_free = r_free + 1'b1;
                n_steps = r_steps + 1'b1;
                n_prev  = bt_rdata.next;
                if (bt_rdata.last || r_steps == (BLK_W+1)'(NUM_BLOCKS - 1)) begin
                    res_go = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DWAIT;
                end
            end
            S_RWAIT: begin
                res_go    = 1'b1;
                res_owner = bt_rdata.free ? '0 : bt_rdata.owner;
                res_efree = bt_rdata.free;
                res_next  = bt_rdata.last ? '0 : bt_rdata.next;
                res_elast = bt_rdata.last;
                n_state   = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (res_go) begin
            n_ovalid = 1'b1;
            n_odata  = {6'd0, 9'(n_free), res_elast, res_next, res_efree, res_owner,
                        res_head, res_id, res_st};
            if (r_state == S_IDLE) n_state = S_IDLE;
        end
    end

    assign res = r_odata[49:0];

    // Output register stays empty while a request is in progress.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_DONE) |-> !r_ovalid)
        else $error("result overwritten");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= CNT_W'(NUM_BLOCKS))
        else $error("free count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> $stable(res))
        else $error("result changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> r_state != S_CLEAR)
        else $error("request during clear");
endmodule

// ===== dv/linked_block_allocator_top_tb.sv =====
// Testbench: linked block allocator checked against a behavioral block table model.
`timescale 1ns / 100ps

module linked_block_allocator_top_tb;
    import lba_pkg::*;

    // lowest field last, to match the tdata packing
    typedef struct packed {
        logic [8:0] free_blocks;
        logic       entry_last;
        logic [7:0] entry_next;
        logic       entry_free;
        logic [9:0] entry_owner;
        logic [7:0] head_block;
        logic [9:0] assigned_id;
        logic [2:0] status;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [8:0]  i_cfg_data;

    linked_block_allocator_top u_top (.*);

    // allocation model
    logic        blk_free [NUM_BLOCKS];
    logic [9:0]  blk_owner [NUM_BLOCKS];
    logic        blk_last [NUM_BLOCKS];
    logic [7:0]  blk_next [NUM_BLOCKS];
    logic [7:0]  head_of [NUM_IDS];
    logic        id_busy [NUM_IDS];
    int          free_left;
    int          max_blocks;
    int          min_blocks;
    int          live_ids [$];

    t_result     expected_results [$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatches;
    int          results_seen;
    int          items_sent;
    int          cycles;

    function automatic t_result alloc_predict(t_kind kind, int count, int fid, int bidx);
        t_result r;
        int      id;
        int      prev;
        int      blk;
        int      steps;
        logic    stop;
        logic [7:0] nxt;
        r = '0;
        r.status = ST_OK;
        if (kind == K_CREATE) begin
            if (count == 0) begin
                r.status = ST_CANCEL;
            end else if (count > free_left || count > max_blocks || count < min_blocks) begin
                r.status = ST_SIZE;
            end else begin
                id = 0;
                while (id < NUM_IDS && id_busy[id]) id++;
                if (id >= NUM_IDS) begin
                    r.status = ST_NOID;
                end else begin
                    id_busy[id] = 1'b1;
                    live_ids.push_back(id);
                    prev = 0;
                    for (int k = 0; k < count; k++) begin
                        blk = 0;
                        while (!blk_free[blk]) blk++;
                        blk_free[blk] = 1'b0;
                        blk_owner[blk] = 10'(id);
                        blk_next[blk] = '0;
                        blk_last[blk] = 1'b1;
                        if (k == 0) begin
                            head_of[id] = 8'(blk);
                        end else begin
                            blk_next[prev] = 8'(blk);
                            blk_last[prev] = 1'b0;
                        end
                        prev = blk;
                    end
                    free_left -= count;
                    r.assigned_id = 10'(id);
                    r.head_block = head_of[id];
                end
            end
        end else if (kind == K_DELETE) begin
            if (!id_busy[fid]) begin
                r.status = ST_UNKNOWN;
            end else begin
                blk = head_of[fid];
                for (steps = 0; steps < NUM_BLOCKS; steps++) begin
                    stop = blk_last[blk];
                    nxt = blk_next[blk];
                    if (!blk_free[blk] && free_left < NUM_BLOCKS) free_left++;
                    blk_free[blk] = 1'b1;
                    blk_owner[blk] = '0;
                    blk_next[blk] = '0;
                    blk_last[blk] = 1'b1;
                    if (stop) break;
                    blk = nxt;
                end
                id_busy[fid] = 1'b0;
                foreach (live_ids[i]) if (live_ids[i] == fid) begin
                    live_ids.delete(i);
                    break;
                end
            end
        end else if (kind == K_READ) begin
            r.entry_owner = blk_free[bidx] ? 10'd0 : blk_owner[bidx];
            r.entry_free = blk_free[bidx];
            r.entry_next = blk_last[bidx] ? 8'd0 : blk_next[bidx];
            r.entry_last = blk_last[bidx];
        end
        r.free_blocks = 9'(free_left);
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[49:0];
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want || m_axis_tdata[55:50] !== 6'd0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp st=%0d id=%0d hd=%0d own=%0d fr=%0d nx=%0d ls=%0d fb=%0d / got st=%0d id=%0d hd=%0d own=%0d fr=%0d nx=%0d ls=%0d fb=%0d",
                                want.status, want.assigned_id, want.head_block, want.entry_owner,
                                want.entry_free, want.entry_next, want.entry_last, want.free_blocks,
                                got.status, got.assigned_id, got.head_block, got.entry_owner,
                                got.entry_free, got.entry_next, got.entry_last, got.free_blocks);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // tvalid stays high after a transfer until an idle cycle or a drain drops it; the next request drives new data
    task automatic send_request(t_kind kind, int count, int fid, int bidx);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {5'd0, 8'(bidx), 10'(fid), 9'(count)};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_results.push_back(alloc_predict(kind, count, fid, bidx));
        items_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_limit(t_cfg idx, int value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= 9'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_MAX) max_blocks = value; else min_blocks = value;
        @(posedge i_clk);
    endtask

    task automatic delete_all();
        while (live_ids.size() != 0) send_request(K_DELETE, 0, live_ids[0], 0);
    endtask

    task automatic test_directed();
        send_request(K_READ, 0, 0, 0);
        send_request(K_READ, 0, 0, 255);
        send_request(K_CREATE, 0, 0, 0);
        send_request(K_CREATE, 1, 0, 0);
        send_request(K_CREATE, 21, 0, 0);
        send_request(K_CREATE, 511, 0, 0);
        send_request(K_CREATE, 2, 0, 0);
        send_request(K_CREATE, 20, 0, 0);
        send_request(K_READ, 0, 0, 1);
        send_request(K_READ, 0, 0, 21);
        send_request(K_DELETE, 0, 0, 0);
        send_request(K_DELETE, 0, 1023, 0);
        send_request(K_DELETE, 0, 0, 0);
        send_request(K_NONE, 511, 1023, 255);
        send_request(K_CREATE, 3, 0, 0);
        send_request(K_READ, 0, 0, 0);
        delete_all();
    endtask

    task automatic test_config_extremes();
        write_limit(CFG_MAX, 256);
        write_limit(CFG_MIN, 256);
        send_request(K_CREATE, 256, 0, 0);
        send_request(K_READ, 0, 0, 255);
        send_request(K_READ, 0, 0, 128);
        send_request(K_CREATE, 256, 0, 0);
        delete_all();
        write_limit(CFG_MIN, 1);
        write_limit(CFG_MAX, 1);
        send_request(K_CREATE, 1, 0, 0);
        send_request(K_CREATE, 2, 0, 0);
        write_limit(CFG_MIN, 5);
        send_request(K_CREATE, 3, 0, 0);
        drain_results();
    endtask

    // fill the disk with four-block files, then ask for more
    task automatic test_disk_full();
        write_limit(CFG_MIN, 1);
        write_limit(CFG_MAX, 4);
        delete_all();
        while (live_ids.size() < 64) send_request(K_CREATE, 4, 0, 0);
        send_request(K_CREATE, 1, 0, 0);
        send_request(K_CREATE, 4, 0, 0);
        delete_all();
    endtask

    task automatic random_phase(int n, int idle, int stall);
        int    r;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 45) begin
                send_request(K_CREATE,
                    ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(max_blocks + 1),
                    $urandom_range(1023), $urandom_range(255));
            end else if (r < 70 && live_ids.size() != 0) begin
                send_request(K_DELETE, $urandom_range(511),
                    live_ids[$urandom_range(live_ids.size() - 1)], $urandom_range(255));
            end else if (r < 75) begin
                send_request(K_DELETE, $urandom_range(511), $urandom_range(1023),
                    $urandom_range(255));
            end else if (r < 97) begin
                send_request(K_READ, $urandom_range(511), $urandom_range(1023),
                    $urandom_range(255));
            end else begin
                send_request(K_NONE, $urandom_range(511), $urandom_range(1023),
                    $urandom_range(255));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = K_CREATE;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MAX;
        i_cfg_data = '0;
        cycles = 0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            blk_free[i] = 1'b1; blk_owner[i] = '0; blk_last[i] = 1'b1; blk_next[i] = '0;
        end
        for (int i = 0; i < NUM_IDS; i++) begin
            id_busy[i] = 1'b0; head_of[i] = '0;
        end
        free_left = NUM_BLOCKS;
        max_blocks = MAX_RESET;
        min_blocks = MIN_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_config_extremes();
        test_disk_full();
        write_limit(CFG_MAX, 20);
        write_limit(CFG_MIN, 2);
        random_phase(125, 0, 0);
        random_phase(125, 45, 0);
        drain_results();
        random_phase(125, 0, 45);
        write_limit(CFG_MAX, 64);
        write_limit(CFG_MIN, 1);
        random_phase(125, 20, 20);
        drain_results();
        write_limit(CFG_MAX, 8);
        write_limit(CFG_MIN, 9);
        random_phase(30, 0, 0);
        drain_results();
        repeat (200) @(posedge i_clk);

        $display("covered create/cancel/size, full disk, delete known and unknown, table reads,");
        $display("%0d requests, %0d results, limits at extremes, four idle mixes",
            items_sent, results_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_results.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/lba_pkg.sv
sv/linked_block_allocator_top.sv
dv/linked_block_allocator_top_tb.sv
